/* hw/rtl/fpa_pkg.sv */
// Package for the fixed partition allocator: sizing constants, status codes,
// request and result payload types, and the token that walks the cell row.
// No dependencies; every other file imports it.
package fpa_pkg;

  localparam int MEMORY_BYTES    = 1024;
  localparam int PARTITION_COUNT = 4;
  localparam int PART_BYTES      = MEMORY_BYTES / PARTITION_COUNT;

  localparam int IDX_W = (PARTITION_COUNT > 1) ? $clog2(PARTITION_COUNT) : 1;
  localparam int CNT_W = $clog2(PARTITION_COUNT + 1);

  localparam int OWNER_W = 16;
  localparam int BYTES_W = 11;
  localparam int SLOT_W  = 2;
  localparam int FREE_W  = 3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_FREED     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic               mode;
    logic [OWNER_W-1:0] owner_id;
    logic [BYTES_W-1:0] request_bytes;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [FREE_W-1:0] free_count;
  } result_t;

  // Request as it travels from cell to cell.
  typedef struct packed {
    logic               valid;
    logic               mode;
    logic [OWNER_W-1:0] owner_id;
    logic               too_large;
    logic               served;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   slot;
    logic [CNT_W-1:0]   free_cnt;
  } fpa_token_t;

endpackage

/* hw/rtl/fpa_cell.sv */
// One partition of the allocator: occupied mark and owner id, plus the
// token register that hands the request on to the next cell.
// Depends on fpa_pkg.
module fpa_cell
  import fpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  fpa_token_t tok_in,
  output fpa_token_t tok_out
);

  logic               occupied;
  logic [OWNER_W-1:0] owner;
  logic               hit;
  logic               occ_after;

  function automatic logic tin_is_free();
    return tok_in.mode == MODE_FREE;
  endfunction

  always_comb begin
    if (tin_is_free()) begin
      hit = occupied && (owner == tok_in.owner_id);
    end else begin
      hit = !occupied;
    end
    hit       = hit && tok_in.valid && !tok_in.served && !tok_in.too_large;
    occ_after = hit ? (tok_in.mode == MODE_ALLOC) : occupied;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (hit) begin
      occupied <= (tok_in.mode == MODE_ALLOC);
    end
  end

  always_ff @(posedge clk) begin
    if (hit && tok_in.mode == MODE_ALLOC) begin
      owner <= tok_in.owner_id;
    end
  end

  // Only the valid bit is reset; the rest of the token is ignored while it is low.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.mode      <= tok_in.mode;
    tok_out.owner_id  <= tok_in.owner_id;
    tok_out.too_large <= tok_in.too_large;
    tok_out.served    <= tok_in.served | hit;
    tok_out.idx       <= tok_in.idx + IDX_W'(1);
    tok_out.slot      <= hit ? tok_in.idx : tok_in.slot;
    tok_out.free_cnt  <= tok_in.free_cnt + {{(CNT_W-1){1'b0}}, ~occ_after};
  end

endmodule

/* hw/rtl/fixed_partition_allocator.sv */
// Fixed partition first-fit allocator: a row of PARTITION_COUNT cells.
// The request walks the cell registers in order, cell 0 first, up to the result strobe.
// A new request is taken only once the previous token has left every cell but the last.
// Reset (synchronous, active high) marks every partition free.
// The result is shown for one cycle only; the receiver cannot stall it.
module fixed_partition_allocator
  import fpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     result_valid,
  output result_t  result
);

  // tok[i] is the input of cell i; tok[PARTITION_COUNT] leaves the last cell.
  fpa_token_t                 tok [PARTITION_COUNT+1];
  logic [PARTITION_COUNT-1:0] in_flight;
  logic                       accept;
  fpa_token_t                 last;

  // A request is taken only when no token is left in the row short of the
  // last cell, so a new request may enter in the same cycle as a result.
  assign accept = start && !busy;

  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = accept;
    tok[0].mode      = request.mode;
    tok[0].owner_id  = request.owner_id;
    tok[0].too_large = (request.mode == MODE_ALLOC) &&
                       (32'(request.request_bytes) > PART_BYTES);
  end

  // Each cell looks at its own partition once the token reaches it and
  // passes on whether the request has been served, the slot it took, and
  // the running count of partitions that are free after this request.
  for (genvar i = 0; i < PARTITION_COUNT; i++) begin : g_cell
    fpa_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
    assign in_flight[i] = tok[i+1].valid;
  end

  assign busy = |in_flight[PARTITION_COUNT-2:0];

  assign last         = tok[PARTITION_COUNT];
  assign result_valid = last.valid;

  always_comb begin
    if (last.mode == MODE_FREE) begin
      result.status = last.served ? ST_FREED : ST_NOT_FOUND;
    end else if (last.too_large) begin
      result.status = ST_TOO_LARGE;
    end else begin
      result.status = last.served ? ST_ALLOCATED : ST_NO_FREE;
    end
    result.slot       = last.served ? SLOT_W'(last.slot) : '0;
    result.free_count = FREE_W'(last.free_cnt);
  end

`ifndef ASSERT_OFF
  // Only one request is ever in the row.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(in_flight) <= 1)
    else $error("more than one request in the cell row");

  // Every accepted request comes out after exactly one pass of the row.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PARTITION_COUNT result_valid)
    else $error("result strobe missing after the row pass");

  // A successful allocation leaves at least one partition taken.
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_ALLOCATED |->
      32'(result.free_count) < PARTITION_COUNT)
    else $error("allocation reported with every partition free");

  // A release leaves at least one partition free.
  a_free_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_FREED |-> result.free_count != '0)
    else $error("release reported with no partition free");
`endif

endmodule

/* tb/fixed_partition_allocator_tb.sv */
// Self-checking testbench for the fixed partition first-fit allocator.
// Depends on fpa_pkg (sizes, status codes, payload types) and the allocator RTL.
`timescale 1ns / 100ps

module fixed_partition_allocator_tb;
  import fpa_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 2 * PARTITION_COUNT + 4;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  request_t request = '0;
  logic     result_valid;
  result_t  result;

  // Requests still to be offered, and the results the allocator owes us in order.
  request_t pending_requests[$];
  result_t  expected_results[$];

  // Our own picture of the partition table. Sizes are never visible at the
  // result ports, so only the occupied marks and the owners are tracked.
  bit               part_used[PARTITION_COUNT];
  logic [OWNER_W-1:0] part_owner[PARTITION_COUNT];

  int          total_items = 0;
  int          accepted_count = 0;
  int          mismatch_count = 0;
  int unsigned idle_pct;
  result_t     oldest;

  fixed_partition_allocator DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .result_valid(result_valid),
    .result      (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // First fit: an allocate takes the lowest free partition unless it is larger
  // than one partition; a free releases the lowest occupied partition owned by
  // the id. Refused requests report slot 0 and leave the table alone.
  function automatic result_t predict_allocation(request_t req);
    result_t res;
    bit      done;
    int      n_free;
    res.slot = '0;
    done = 1'b0;
    n_free = 0;
    if (req.mode == MODE_ALLOC) begin
      if (int'(req.request_bytes) > PART_BYTES) begin
        res.status = ST_TOO_LARGE;
      end else begin
        res.status = ST_NO_FREE;
        for (int i = 0; i < PARTITION_COUNT; i++) begin
          if (!done && !part_used[i]) begin
            part_used[i] = 1'b1;
            part_owner[i] = req.owner_id;
            res.status = ST_ALLOCATED;
            res.slot = SLOT_W'(i);
            done = 1'b1;
          end
        end
      end
    end else begin
      res.status = ST_NOT_FOUND;
      for (int i = 0; i < PARTITION_COUNT; i++) begin
        if (!done && part_used[i] && part_owner[i] == req.owner_id) begin
          part_used[i] = 1'b0;
          res.status = ST_FREED;
          res.slot = SLOT_W'(i);
          done = 1'b1;
        end
      end
    end
    for (int i = 0; i < PARTITION_COUNT; i++) begin
      if (!part_used[i]) n_free++;
    end
    res.free_count = FREE_W'(n_free);
    return res;
  endfunction

  task automatic queue_request(input logic mode, input int owner, input int nbytes);
    request_t r;
    r.mode = mode;
    r.owner_id = OWNER_W'(owner);
    r.request_bytes = BYTES_W'(nbytes);
    pending_requests.push_back(r);
  endtask

  // Driver. A transfer happens at an edge where start is high and busy is low;
  // that is where the expectation is formed from the request actually held on
  // the port. A request that has not been taken yet is held steady. Otherwise
  // the next request is offered, or start is dropped for an idle cycle. Each
  // branch makes exactly one assignment to start, so a request that follows
  // straight on keeps start high without a glitch.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (accepted_count < total_items / 3) begin
        idle_pct = 33;
      end else if (accepted_count < (2 * total_items) / 3) begin
        idle_pct = 77;
      end else begin
        idle_pct = 0;
      end
      if (start && !busy) begin
        expected_results.push_back(predict_allocation(request));
        accepted_count++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
        request <= pending_requests.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. The strobe lasts one cycle and cannot be stalled, so every edge
  // with result_valid high is a transfer that must match the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d slot %0d free_count %0d",
                 $time, result.status, result.slot, result.free_count);
        mismatch_count++;
      end else begin
        oldest = expected_results.pop_front();
        if (result.status !== oldest.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, oldest.status, result.status);
          mismatch_count++;
        end
        if (result.slot !== oldest.slot) begin
          $display("%0t: slot mismatch: expected %0d, actual %0d",
                   $time, oldest.slot, result.slot);
          mismatch_count++;
        end
        if (result.free_count !== oldest.free_count) begin
          $display("%0t: free_count mismatch: expected %0d, actual %0d",
                   $time, oldest.free_count, result.free_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [OWNER_W-1:0] owner_pool[6];
    request_t           r;

    for (int i = 0; i < PARTITION_COUNT; i++) begin
      part_used[i] = 1'b0;
      part_owner[i] = '0;
    end

    // Directed part. Fill the table, including a zero-byte request and a
    // duplicate owner, try sizes just past the partition and at the top of
    // the field, then ask once more when every partition is taken.
    queue_request(MODE_ALLOC, 0, 0);
    queue_request(MODE_ALLOC, 16'hFFFF, PART_BYTES);
    queue_request(MODE_ALLOC, 0, PART_BYTES + 1);
    queue_request(MODE_ALLOC, 5, MEMORY_BYTES);
    queue_request(MODE_ALLOC, 5, 2047);
    queue_request(MODE_ALLOC, 0, 100);
    queue_request(MODE_ALLOC, 16'h1234, PART_BYTES - 1);
    queue_request(MODE_ALLOC, 7, 1);
    // Duplicate owners come back lowest slot first; a third free of the same
    // owner, and a second free of one already released, must find nothing.
    queue_request(MODE_FREE, 0, 2047);
    queue_request(MODE_FREE, 0, 0);
    queue_request(MODE_FREE, 0, 0);
    queue_request(MODE_FREE, 16'hFFFF, 0);
    queue_request(MODE_FREE, 16'hFFFF, 0);
    queue_request(MODE_FREE, 9, 0);
    queue_request(MODE_ALLOC, 16'h5555, 16'h2AA);
    queue_request(MODE_ALLOC, 16'hAAAA, 16'h0AA);
    queue_request(MODE_FREE, 16'h1234, 16'h555);
    queue_request(MODE_FREE, 16'hAAAA, 0);
    queue_request(MODE_FREE, 16'h5555, 0);
    queue_request(MODE_FREE, 16'h0000, 0);

    // Random part. Owners are drawn mostly from a small pool so that frees
    // usually find their partition and the table keeps filling and draining;
    // the rest are arbitrary ids that rarely match anything.
    foreach (owner_pool[i]) owner_pool[i] = OWNER_W'($urandom);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r.mode = ($urandom_range(99) < 55) ? MODE_ALLOC : MODE_FREE;
      r.owner_id = ($urandom_range(9) < 8) ? owner_pool[$urandom_range(5)]
                                           : OWNER_W'($urandom);
      case ($urandom_range(9))
        0: r.request_bytes = BYTES_W'($urandom);
        1: r.request_bytes = BYTES_W'(PART_BYTES);
        2: r.request_bytes = BYTES_W'(PART_BYTES + 1);
        default: r.request_bytes = BYTES_W'($urandom_range(PART_BYTES));
      endcase
      pending_requests.push_back(r);
    end
    total_items = pending_requests.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken and answered, then run on for the drain
    // period so that a stray extra strobe would still be caught.
    while (accepted_count < total_items || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("fixed_partition_allocator_tb passed");
    end else begin
      $display("fixed_partition_allocator_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of these requests.
  initial begin
    #5ms;
    $display("fixed_partition_allocator_tb failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_cell.sv
hw/rtl/fixed_partition_allocator.sv
tb/fixed_partition_allocator_tb.sv
